[src/cle_pkg.sv]
// Shared types and codes of the circular list engine.
`timescale 1ns / 1ps
package cle_pkg;

   typedef enum logic [2:0] {
      ACT_IF_EMPTY = 3'd0,
      ACT_FRONT    = 3'd1,
      ACT_BACK     = 3'd2,
      ACT_AFTER    = 3'd3,
      ACT_DUMP     = 3'd4
   } act_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_START,
      S_HEAD,
      S_FIRST,
      S_WALK,
      S_INS_CAP,
      S_LINK_A,
      S_LINK_B
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;    // capture request word, at <= tail
      logic       addr_link;   // read address from link read data, else from at
      logic       step_clr;
      logic       step_inc;
      logic       wr_start;    // one-node list at slot 0
      logic       wr_new;      // write new node (value, next)
      logic       wr_at;       // relink node at to new node, bump count
      logic       at_from_ptr;
      logic       next_cap;
      logic       emit;
      logic       emit_elem;
      logic       emit_final;
      status_type emit_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] action;
      logic       empty;
      logic       full;
      logic       match;
      logic       last;
   } dp_stat_type;

endpackage

[src/circular_list_engine.sv]
// Top level of the circular list engine: sequencer plus datapath.
`timescale 1ns / 1ps
//
//  channel   ports                                       handshake
//  --------  ------------------------------------------  ------------------------
//  request   req_action, req_value, req_key              start & !busy
//  response  rsp_status, rsp_element, rsp_final_item     rsp_valid, one cycle each
//
//  One request word at a time; busy stays high until its last response word.
//  Reject/ignore/empty/full replies: decided in dispatch, reply the cycle after.
//  Insert front/back: dispatch, head, capture, link A, link B; into an empty
//  list: dispatch, start. Insert-after-match: dispatch, head, first, walk to the
//  match (all nodes if the key is absent), link A, link B. Dump: dispatch, head,
//  first, walk, one word per cycle. The walk is paced by one node-store read
//  per cycle. Reset (synchronous) empties the list; node stores are not cleared.
//  Response words cannot be held off by the receiver.
//
module circular_list_engine #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_element,
   output logic               rsp_final_item
);

   cle_pkg::cmd_type     cmd;
   cle_pkg::dp_stat_type stat;

   // sequencer: dispatch, walk control, two-step relink
   cle_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // node stores, tail/count, response word register
   cle_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_element    (rsp_element),
      .rsp_final_item (rsp_final_item)
   );

endmodule

[src/cle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cle_ctrl.sv]
// Sequencer of the circular list engine.
`timescale 1ns / 1ps
module cle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cle_pkg::dp_stat_type stat,
   output cle_pkg::cmd_type     cmd
);

   cle_pkg::state_type state_ff, state_in;
   logic act_dump, act_after, act_bad, act_if_empty;

   assign act_dump     = (stat.action == cle_pkg::ACT_DUMP);
   assign act_after    = (stat.action == cle_pkg::ACT_AFTER);
   assign act_if_empty = (stat.action == cle_pkg::ACT_IF_EMPTY);
   assign act_bad      = (stat.action > cle_pkg::ACT_DUMP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cle_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != cle_pkg::S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cle_pkg::S_IDLE: begin
            if (start) state_in = cle_pkg::S_DISPATCH;
         end
         cle_pkg::S_DISPATCH: begin
            if (act_bad) begin
               state_in = cle_pkg::S_IDLE;
            end else if (act_if_empty) begin
               state_in = stat.empty ? cle_pkg::S_START : cle_pkg::S_IDLE;
            end else if (act_dump) begin
               state_in = stat.empty ? cle_pkg::S_IDLE : cle_pkg::S_HEAD;
            end else if (stat.empty) begin
               state_in = cle_pkg::S_START;
            end else if (stat.full) begin
               state_in = cle_pkg::S_IDLE;
            end else begin
               state_in = cle_pkg::S_HEAD;
            end
         end
         cle_pkg::S_START:   state_in = cle_pkg::S_IDLE;
         cle_pkg::S_HEAD: begin
            state_in = (act_dump || act_after) ? cle_pkg::S_FIRST : cle_pkg::S_INS_CAP;
         end
         cle_pkg::S_FIRST:   state_in = cle_pkg::S_WALK;
         cle_pkg::S_WALK: begin
            if (act_dump) begin
               if (stat.last) state_in = cle_pkg::S_IDLE;
            end else if (stat.match) begin
               state_in = cle_pkg::S_LINK_A;
            end else if (stat.last) begin
               state_in = cle_pkg::S_IDLE;
            end
         end
         cle_pkg::S_INS_CAP: state_in = cle_pkg::S_LINK_A;
         cle_pkg::S_LINK_A:  state_in = cle_pkg::S_LINK_B;
         cle_pkg::S_LINK_B:  state_in = cle_pkg::S_IDLE;
         default:            state_in = cle_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.emit_status = cle_pkg::ST_OK;
      case (state_ff)
         cle_pkg::S_IDLE: begin
            cmd.load_req = start;
         end
         cle_pkg::S_DISPATCH: begin
            cmd.emit_final = 1'b1;
            if (act_bad) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = cle_pkg::ST_IGNORED;
            end else if (act_if_empty) begin
               if (!stat.empty) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = cle_pkg::ST_IGNORED;
               end
            end else if (act_dump) begin
               if (stat.empty) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = cle_pkg::ST_EMPTY;
               end
            end else if (!stat.empty && stat.full) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = cle_pkg::ST_FULL;
            end
         end
         cle_pkg::S_START: begin
            cmd.wr_start   = 1'b1;
            cmd.emit       = 1'b1;
            cmd.emit_final = 1'b1;
         end
         cle_pkg::S_HEAD: begin
            cmd.addr_link = 1'b0;  // read link of tail
         end
         cle_pkg::S_FIRST: begin
            cmd.addr_link = 1'b1;
            cmd.step_clr  = 1'b1;
         end
         cle_pkg::S_WALK: begin
            cmd.addr_link = 1'b1;
            cmd.step_inc  = 1'b1;
            if (act_dump) begin
               cmd.emit       = 1'b1;
               cmd.emit_elem  = 1'b1;
               cmd.emit_final = stat.last;
            end else if (stat.match) begin
               cmd.at_from_ptr = 1'b1;
               cmd.next_cap    = 1'b1;
            end else if (stat.last) begin
               cmd.emit        = 1'b1;
               cmd.emit_final  = 1'b1;
               cmd.emit_status = cle_pkg::ST_NOT_FOUND;
            end
         end
         cle_pkg::S_INS_CAP: begin
            cmd.next_cap = 1'b1;
         end
         cle_pkg::S_LINK_A: begin
            cmd.wr_new = 1'b1;
         end
         cle_pkg::S_LINK_B: begin
            cmd.wr_at      = 1'b1;
            cmd.emit       = 1'b1;
            cmd.emit_final = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[src/cle_dp.sv]
// Datapath of the circular list engine: node stores, list registers, result word.
`timescale 1ns / 1ps
module cle_dp #(
   parameter int CAPACITY = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cle_pkg::cmd_type     cmd,
   output cle_pkg::dp_stat_type stat,
   input  logic [2:0]          req_action,
   input  logic signed [31:0]  req_value,
   input  logic signed [31:0]  req_key,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_element,
   output logic                rsp_final_item
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [2:0]    action_ff;
   logic [31:0]   value_ff, key_ff;
   logic [IW-1:0] tail_ff, at_ff, ptr_ff, next_ff;
   logic [CW-1:0] count_ff, steps_ff;
   logic          rsp_valid_ff, rsp_final_ff;
   logic [2:0]    rsp_status_ff;
   logic [31:0]   rsp_element_ff;

   logic [IW-1:0] rd_addr, new_idx, link_rdata, link_waddr, link_wdata;
   logic [31:0]   val_rdata, val_wdata, start_val;
   logic [IW-1:0] val_waddr;
   logic          val_we, link_we, tail_moves;

   assign new_idx   = count_ff[IW-1:0];
   assign rd_addr   = cmd.addr_link ? link_rdata : at_ff;
   assign start_val = (action_ff == cle_pkg::ACT_AFTER) ? key_ff : value_ff;
   // new node becomes the tail on a back insert or an insert after the tail node
   assign tail_moves = (action_ff == cle_pkg::ACT_BACK) ||
                       ((action_ff == cle_pkg::ACT_AFTER) && (at_ff == tail_ff));

   assign val_we    = cmd.wr_start | cmd.wr_new;
   assign val_waddr = cmd.wr_start ? '0 : new_idx;
   assign val_wdata = cmd.wr_start ? start_val : value_ff;

   assign link_we    = cmd.wr_start | cmd.wr_new | cmd.wr_at;
   assign link_waddr = cmd.wr_at ? at_ff : (cmd.wr_start ? '0 : new_idx);
   assign link_wdata = cmd.wr_at ? new_idx : (cmd.wr_start ? '0 : next_ff);

   cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   cle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= rd_addr;
      if (cmd.load_req) begin
         action_ff <= req_action;
         value_ff  <= req_value;
         key_ff    <= req_key;
         at_ff     <= tail_ff;
      end else if (cmd.at_from_ptr) begin
         at_ff <= ptr_ff;
      end
      if (cmd.next_cap) next_ff <= link_rdata;
      if (cmd.step_clr) begin
         steps_ff <= '0;
      end else if (cmd.step_inc) begin
         steps_ff <= steps_ff + CW'(1);
      end
      rsp_status_ff  <= cmd.emit_status;
      rsp_element_ff <= cmd.emit_elem ? val_rdata : 32'd0;
      rsp_final_ff   <= cmd.emit_final;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (cmd.wr_start) begin
            tail_ff  <= '0;
            count_ff <= CW'(1);
         end else if (cmd.wr_at) begin
            count_ff <= count_ff + CW'(1);
            if (tail_moves) tail_ff <= new_idx;
         end
      end
   end

   assign stat.action = action_ff;
   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff == CW'(CAPACITY));
   assign stat.match  = (val_rdata == key_ff);
   assign stat.last   = (steps_ff == (count_ff - CW'(1)));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_element    = rsp_element_ff;
   assign rsp_final_item = rsp_final_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("node count beyond capacity");

   a_tail_in_use: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> ({1'b0, tail_ff} < {1'b0, count_ff}))
      else $error("tail outside allocated nodes");

   a_dump_streams: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_final_ff) |=> rsp_valid_ff)
      else $error("dump stream broken before final word");

   a_elem_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != cle_pkg::ST_OK)) |-> (rsp_element_ff == 32'd0))
      else $error("element nonzero on non-ok word");

   a_grow_one: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("node count moved by more than one");

endmodule
